>>> src/ihex_pkg.sv
// Package for the Intel HEX record parser: status codes, character constants,
// field widths, the result struct and the digit and type-rule functions.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    localparam int unsigned CAPACITY = 16777216;
    localparam int unsigned ADDR_W   = 25;
    localparam int unsigned POS_W    = 10;

    localparam logic [ADDR_W-1:0] BYTES_CAP = ADDR_W'(CAPACITY);
    localparam logic [POS_W-1:0]  POS_MAX   = '1;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] BAD_BYTE  = 8'hFF;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_EOF      = 3'd3;
    localparam logic [2:0] ST_BADSTART = 3'd4;
    localparam logic [2:0] ST_BADHEX   = 3'd5;
    localparam logic [2:0] ST_BADTYPE  = 3'd6;
    localparam logic [2:0] ST_SHORT    = 3'd7;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        byte_value;
        logic [ADDR_W-1:0] byte_address;
        logic [2:0]        status;
    } t_result;

    // Bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = {1'b0, c[3:0] + 4'd9};
        end
        return d;
    endfunction

    function automatic logic [2:0] type_verdict(input logic [7:0] len, input logic [7:0] typ);
        logic [2:0] v;
        v = (typ == 8'd0) ? ST_OK : ST_BADTYPE;
        if (len == 8'd0) begin
            v = (typ == 8'd1) ? ST_EOF : ST_BADTYPE;
        end else if (len == 8'd2) begin
            if (typ == 8'd2 || typ == 8'd4) begin
                v = ST_IGNORED;
            end else if (typ == 8'd3 || typ == 8'd5) begin
                v = ST_BADTYPE;
            end
        end else if (len == 8'd4) begin
            if (typ == 8'd3 || typ == 8'd5) begin
                v = ST_IGNORED;
            end else if (typ == 8'd2 || typ == 8'd4) begin
                v = ST_BADTYPE;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/ihex_if.sv
// Handshake interfaces of the Intel HEX record parser: the character channel
// and the result channel. Depends on ihex_pkg for the address width.
`timescale 1ns / 1ps
`default_nettype none

interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface ihex_result_if
    import ihex_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [7:0]        byte_value;
    logic [ADDR_W-1:0] byte_address;
    logic [2:0]        status;

    modport source (output valid, output kind, output byte_value, output byte_address,
                    output status, input ready);
    modport sink (input valid, input kind, input byte_value, input byte_address,
                  input status, output ready);
endinterface

`default_nettype wire

>>> src/intel_hex_record_parser.sv
// Intel HEX record parser top level: input register, record decoder and
// result register. Depends on ihex_pkg, ihex_if and the three ihex modules.
//
// Usage: the text arrives one character per item on i_char (valid/ready).
// Each data byte of a data record, up to CAPACITY bytes in all, gives one
// result item on o_res with kind 0, its value and its address (first data
// record address plus bytes emitted so far). Each line feed gives one
// status item with kind 1. All other characters give no result.
// A result is registered in the result register after its character has
// passed through the input register and the decoder step; while o_res is not
// stalled one character is accepted every cycle, set by the single step of
// the decoder between the input register and the result register.
// While o_res is stalled the result register holds its item, the input
// register holds the next character, and i_char.ready drops once both are
// full. Reset clears all parse state, the byte count and the halt flag; an
// end-of-file record or a fatal error halts the parser until the next reset;
// while halted, characters are still accepted but give no result.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    ihex_char_if.sink     i_char,
    ihex_result_if.source o_res
);

    logic       advance;
    logic       in_valid;
    logic [7:0] in_char;
    logic       res_valid;
    t_result    res;

    ihex_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_char    (in_char)
    );

    ihex_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_valid && advance),
        .i_char      (in_char),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ihex_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_advance   (advance),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

>>> src/ihex_in_reg.sv
// Input register of the parser: holds one accepted character until the
// decoder steps on it. Depends on ihex_pkg and ihex_char_if.
`timescale 1ns / 1ps
`default_nettype none

module ihex_in_reg
    import ihex_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ihex_char_if.sink   i_char,
    input  wire         i_advance,
    output logic        o_valid,
    output logic [7:0]  o_char
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       n_valid;

    assign i_char.ready = !r_valid || i_advance;
    assign n_valid      = i_char.ready ? i_char.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_in;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

`default_nettype wire

>>> src/ihex_decoder.sv
// Record decoder: parse state and the per-character step logic that turns one
// character into at most one result. Depends on ihex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihex_decoder
    import ihex_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_step,
    input  wire  [7:0]  i_char,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [7:0]        r_len,     n_len;
    logic [15:0]       r_addr,    n_addr;
    logic [7:0]        r_type,    n_type;
    logic [7:0]        r_sum,     n_sum;
    logic [4:0]        r_held,    n_held;
    logic [2:0]        r_pending, n_pending;
    logic              r_cks_ok,  n_cks_ok;
    logic [15:0]       r_start,   n_start;
    logic              r_known,   n_known;
    logic [ADDR_W-1:0] r_bytes,   n_bytes;
    logic              r_halted,  n_halted;

    logic [4:0]        digit;
    logic              bad;
    logic [7:0]        value;
    logic [8:0]        data_idx;
    logic [10:0]       full_len;
    logic [2:0]        st;
    logic [2:0]        verdict;

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_addr    = r_addr;
        n_type    = r_type;
        n_sum     = r_sum;
        n_held    = r_held;
        n_pending = r_pending;
        n_cks_ok  = r_cks_ok;
        n_start   = r_start;
        n_known   = r_known;
        n_bytes   = r_bytes;
        n_halted  = r_halted;
        o_res_valid = 1'b0;
        o_res       = '0;

        digit    = digit_of(i_char);
        bad      = r_held[4] || digit[4];
        value    = bad ? BAD_BYTE : {r_held[3:0], digit[3:0]};
        data_idx = r_pos[POS_W-1:1] - 9'd5;
        full_len = 11'd11 + {2'b00, r_len, 1'b0};
        verdict  = type_verdict(r_len, value);
        st       = ST_OK;

        if (i_step && !r_halted) begin
            if (i_char == CH_LF) begin
                if (r_pending != ST_OK) begin
                    st = r_pending;
                end else if (r_pos == '0) begin
                    st = ST_BADSTART;
                end else if (r_pos < POS_W'(9)) begin
                    st = ST_BADHEX;
                end else if ({1'b0, r_pos} < full_len) begin
                    st = ST_SHORT;
                end else begin
                    st = r_cks_ok ? ST_OK : ST_MISMATCH;
                end
                if (st == ST_EOF || st == ST_BADSTART || st == ST_BADHEX
                        || st == ST_BADTYPE) begin
                    n_halted = 1'b1;
                end
                n_pos     = '0;
                n_len     = '0;
                n_addr    = '0;
                n_type    = '0;
                n_sum     = '0;
                n_held    = '0;
                n_pending = ST_OK;
                n_cks_ok  = 1'b0;
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_STATUS;
                o_res.status        = st;
            end else if (i_char > CH_SPACE && i_char != CH_DEL) begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + POS_W'(1);
                end
                if (r_pending == ST_OK) begin
                    if (r_pos == '0) begin
                        if (i_char != CH_COLON) begin
                            n_pending = ST_BADSTART;
                        end
                    end else if (r_pos[0]) begin
                        n_held = digit;
                    end else if (r_pos <= POS_W'(8)) begin
                        if (bad) begin
                            n_pending = ST_BADHEX;
                        end else begin
                            case (r_pos[3:1])
                                3'd1: begin
                                    n_len = value;
                                    n_sum = r_sum + value;
                                end
                                3'd2: begin
                                    n_addr = {value, 8'h00};
                                    n_sum  = r_sum + value;
                                end
                                3'd3: begin
                                    n_addr = {r_addr[15:8], value};
                                    n_sum  = r_sum + value;
                                end
                                default: begin
                                    n_type    = value;
                                    n_pending = verdict;
                                    if (verdict == ST_OK && !r_known) begin
                                        n_start = r_addr;
                                        n_known = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end else if (data_idx < {1'b0, r_len}) begin
                        n_sum = r_sum + value;
                        if (r_bytes < BYTES_CAP) begin
                            o_res_valid        = 1'b1;
                            o_res.kind         = KIND_DATA;
                            o_res.byte_value   = value;
                            o_res.byte_address = {{(ADDR_W-16){1'b0}}, r_start} + r_bytes;
                            n_bytes            = r_bytes + ADDR_W'(1);
                        end
                    end else if (data_idx == {1'b0, r_len}) begin
                        n_cks_ok = !bad && (value == 8'(8'h00 - r_sum));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_addr    <= '0;
            r_type    <= '0;
            r_sum     <= '0;
            r_held    <= '0;
            r_pending <= ST_OK;
            r_cks_ok  <= 1'b0;
            r_start   <= '0;
            r_known   <= 1'b0;
            r_bytes   <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_addr    <= n_addr;
            r_type    <= n_type;
            r_sum     <= n_sum;
            r_held    <= n_held;
            r_pending <= n_pending;
            r_cks_ok  <= n_cks_ok;
            r_start   <= n_start;
            r_known   <= n_known;
            r_bytes   <= n_bytes;
            r_halted  <= n_halted;
        end
    end

endmodule

`default_nettype wire

>>> src/ihex_out_reg.sv
// Result register of the parser: holds one result item until the receiver
// takes it, and tells the stages before it when they may move.
// Depends on ihex_pkg and ihex_result_if.
`timescale 1ns / 1ps
`default_nettype none

module ihex_out_reg
    import ihex_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_res_valid,
    input  t_result       i_res,
    output logic          o_advance,
    ihex_result_if.source o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.byte_value   = r_res.byte_value;
    assign o_res.byte_address = r_res.byte_address;
    assign o_res.status       = r_res.status;

endmodule

`default_nettype wire
